// ----- sv/microsecond_timer_four_alarms_defines.svh -----
// assertion macros shared by the timer checker
`ifndef MICROSECOND_TIMER_FOUR_ALARMS_DEFINES_SVH
`define MICROSECOND_TIMER_FOUR_ALARMS_DEFINES_SVH

// same-cycle implication, off during reset
`define MT4A_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer check failed");

// next-cycle implication, off during reset
`define MT4A_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer check failed");

// next-cycle implication that also holds across reset
`define MT4A_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("timer check failed");

`endif

// ----- sv/mt4a_pkg.sv -----
package mt4a_pkg;

  localparam int NUM_ALARMS_DEFAULT = 4;
  localparam int IRQ_W = 4;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ALIAS_PLAIN = 2'd0,
    ALIAS_XOR   = 2'd1,
    ALIAS_SET   = 2'd2,
    ALIAS_CLR   = 2'd3
  } alias_t;

  localparam logic [7:0] OFF_TIMEHW     = 8'h00;
  localparam logic [7:0] OFF_TIMELW     = 8'h04;
  localparam logic [7:0] OFF_TIMEHR     = 8'h08;
  localparam logic [7:0] OFF_TIMELR     = 8'h0C;
  localparam logic [7:0] OFF_ALARM_FIRST = 8'h10;
  localparam logic [7:0] OFF_ALARM_LAST = 8'h1C;
  localparam logic [7:0] OFF_ARMED      = 8'h20;
  localparam logic [7:0] OFF_TIMERAWH   = 8'h24;
  localparam logic [7:0] OFF_TIMERAWL   = 8'h28;
  localparam logic [7:0] OFF_PAUSE      = 8'h30;
  localparam logic [7:0] OFF_INTR       = 8'h3C;
  localparam logic [7:0] OFF_INTE       = 8'h40;
  localparam logic [7:0] OFF_INTF       = 8'h44;
  localparam logic [7:0] OFF_INTS       = 8'h48;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  offset;
    logic [1:0]  alias_req;
    logic [31:0] wdata;
    logic [31:0] tick_us;
  } item_t;

  typedef struct packed {
    logic [31:0]      rdata;
    logic [IRQ_W-1:0] irq_status;
    logic [IRQ_W-1:0] irq_pulse;
  } result_t;

endpackage

// ----- sv/mt4a_core.sv -----
module mt4a_core #(
  parameter int NUM_ALARMS = mt4a_pkg::NUM_ALARMS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mt4a_pkg::item_t   item,
  output mt4a_pkg::result_t result
);

  localparam int IrqW = mt4a_pkg::IRQ_W;

  logic [63:0]           time_count, time_next;
  logic [31:0]           alarm_value [NUM_ALARMS];
  logic [31:0]           alarm_next  [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] armed_mask, armed_next;
  logic                  pause_flag, pause_next;
  logic [NUM_ALARMS-1:0] raw_pending, raw_next;
  logic [NUM_ALARMS-1:0] enable_mask, enable_next;
  logic [NUM_ALARMS-1:0] force_mask, force_next;

  logic [63:0]           time_sum;
  logic [31:0]           diff [NUM_ALARMS];
  logic                  alarm_hit;
  logic [31:0]           alarm_rd;
  logic [31:0]           cur;
  logic [31:0]           wv;
  logic [NUM_ALARMS-1:0] status_now, status_next, pulse;

  assign time_sum   = time_count + {32'd0, item.tick_us};
  assign status_now = (raw_pending | force_mask) & enable_mask;

  // alarm compare against the advanced low word, one subtract per alarm
  always_comb begin
    for (int i = 0; i < NUM_ALARMS; i++) begin
      diff[i] = time_sum[31:0] - alarm_value[i];
    end
  end

  always_comb begin
    alarm_hit = (item.offset inside {[mt4a_pkg::OFF_ALARM_FIRST:mt4a_pkg::OFF_ALARM_LAST]})
                && (item.offset[1:0] == 2'd0)
                && ({1'b0, item.offset[3:2]} < 3'(NUM_ALARMS));
    alarm_rd = '0;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      if (item.offset[3:2] == 2'(i)) begin
        alarm_rd = alarm_value[i];
      end
    end
  end

  // register read value
  always_comb begin
    cur = '0;
    if (alarm_hit) begin
      cur = alarm_rd;
    end else begin
      case (item.offset)
        mt4a_pkg::OFF_TIMEHR, mt4a_pkg::OFF_TIMERAWH: cur = time_count[63:32];
        mt4a_pkg::OFF_TIMELR, mt4a_pkg::OFF_TIMERAWL: cur = time_count[31:0];
        mt4a_pkg::OFF_ARMED: cur = 32'(armed_mask);
        mt4a_pkg::OFF_PAUSE: cur = 32'(pause_flag);
        mt4a_pkg::OFF_INTR:  cur = 32'(raw_pending);
        mt4a_pkg::OFF_INTE:  cur = 32'(enable_mask);
        mt4a_pkg::OFF_INTF:  cur = 32'(force_mask);
        mt4a_pkg::OFF_INTS:  cur = 32'(status_now);
        default:             cur = '0;
      endcase
    end
  end

  // alias applied to the read value; set and clear pass through on intr
  always_comb begin
    case (item.alias_req)
      mt4a_pkg::ALIAS_XOR: wv = cur ^ item.wdata;
      mt4a_pkg::ALIAS_SET:
        wv = (item.offset == mt4a_pkg::OFF_INTR) ? item.wdata : (cur | item.wdata);
      mt4a_pkg::ALIAS_CLR:
        wv = (item.offset == mt4a_pkg::OFF_INTR) ? item.wdata : (cur & ~item.wdata);
      default: wv = item.wdata;
    endcase
  end

  always_comb begin
    time_next   = time_count;
    alarm_next  = alarm_value;
    armed_next  = armed_mask;
    pause_next  = pause_flag;
    raw_next    = raw_pending;
    enable_next = enable_mask;
    force_next  = force_mask;
    pulse       = '0;
    status_next = '0;
    result      = '0;

    case (item.cmd)
      mt4a_pkg::CMD_READ: begin
        result.rdata = cur;
      end
      mt4a_pkg::CMD_WRITE: begin
        if (alarm_hit) begin
          for (int i = 0; i < NUM_ALARMS; i++) begin
            if (item.offset[3:2] == 2'(i)) begin
              alarm_next[i] = wv;
              armed_next[i] = 1'b1;
            end
          end
        end else begin
          case (item.offset)
            mt4a_pkg::OFF_TIMEHW: time_next[63:32] = wv;
            mt4a_pkg::OFF_TIMELW: time_next[31:0]  = wv;
            mt4a_pkg::OFF_ARMED:  armed_next = armed_mask & ~wv[NUM_ALARMS-1:0];
            mt4a_pkg::OFF_PAUSE:  pause_next = wv[0];
            mt4a_pkg::OFF_INTR:   raw_next = raw_pending & ~wv[NUM_ALARMS-1:0];
            mt4a_pkg::OFF_INTE: begin
              enable_next = wv[NUM_ALARMS-1:0];
              pulse = (raw_pending | force_mask) & wv[NUM_ALARMS-1:0];
            end
            mt4a_pkg::OFF_INTF: begin
              force_next = wv[NUM_ALARMS-1:0];
              pulse = (raw_pending | wv[NUM_ALARMS-1:0]) & enable_mask;
            end
            default: ;
          endcase
        end
      end
      mt4a_pkg::CMD_TICK: begin
        if (!pause_flag && (item.tick_us != '0)) begin
          time_next = time_sum;
          for (int i = 0; i < NUM_ALARMS; i++) begin
            if (armed_mask[i] && !diff[i][31]) begin
              raw_next[i]   = 1'b1;
              armed_next[i] = 1'b0;
              pulse[i]      = enable_mask[i];
            end
          end
        end
      end
      default: ;
    endcase

    status_next       = (raw_next | force_next) & enable_next;
    result.irq_status = IrqW'(status_next);
    result.irq_pulse  = IrqW'(pulse);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_count  <= '0;
      armed_mask  <= '0;
      pause_flag  <= 1'b0;
      raw_pending <= '0;
      enable_mask <= '0;
      force_mask  <= '0;
      for (int i = 0; i < NUM_ALARMS; i++) begin
        alarm_value[i] <= '0;
      end
    end else if (step) begin
      time_count  <= time_next;
      alarm_value <= alarm_next;
      armed_mask  <= armed_next;
      pause_flag  <= pause_next;
      raw_pending <= raw_next;
      enable_mask <= enable_next;
      force_mask  <= force_next;
    end
  end

endmodule

// ----- sv/microsecond_timer_four_alarms.sv -----
// Microsecond timer with up to four alarms behind a word-wide register port.
// Every input word (a register read, a register write or a time tick) gives
// exactly one result word: read data, the masked interrupt status after the
// word, and the alarms signalled by it. The block takes one word per clock
// cycle while the result side is not stalled. A taken word sits in the input
// register while the logic works on it, and its result is then loaded into
// the result register that drives out_valid once the result side advances. The
// longest path is the tick: the 64-bit time add followed by the parallel
// 32-bit alarm compares. While a result waits, the input register can still
// take one more word; once both registers are full, in_ready drops until the
// result word is taken.
module microsecond_timer_four_alarms #(
  parameter int NUM_ALARMS = mt4a_pkg::NUM_ALARMS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  offset,
  input  logic [1:0]  alias_req,
  input  logic [31:0] wdata,
  input  logic [31:0] tick_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] rdata,
  output logic [3:0]  irq_status,
  output logic [3:0]  irq_pulse
);

  mt4a_pkg::item_t   item;
  mt4a_pkg::result_t res_comb;
  logic              item_valid;
  logic              advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= '{cmd: cmd, offset: offset, alias_req: alias_req,
                wdata: wdata, tick_us: tick_us};
    end
  end

  mt4a_core #(
    .NUM_ALARMS(NUM_ALARMS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (item_valid && advance),
    .item   (item),
    .result (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  // result word holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      rdata      <= res_comb.rdata;
      irq_status <= res_comb.irq_status;
      irq_pulse  <= res_comb.irq_pulse;
    end
  end

endmodule

// ----- sv/mt4a_checker.sv -----
`include "microsecond_timer_four_alarms_defines.svh"

module mt4a_checker #(
  parameter int NUM_ALARMS = mt4a_pkg::NUM_ALARMS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rdata,
  input logic [3:0]  irq_status,
  input logic [3:0]  irq_pulse
);

  logic        out_stall;
  logic [3:0]  extra_bits;
  logic [39:0] out_word;

  assign out_stall  = out_valid && !out_ready;
  assign extra_bits = (irq_status | irq_pulse) >> NUM_ALARMS;
  assign out_word   = {rdata, irq_status, irq_pulse};

  `MT4A_ASSERT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)

  `MT4A_ASSERT_NEXT(a_out_held, clk, rst, out_stall, out_valid)

  // a signalled alarm is always visible in the status that goes with it
  `MT4A_ASSERT_NOW(a_pulse_in_status, clk, rst, out_valid, (irq_pulse & ~irq_status) == 4'd0)

  // no status or pulse bits for alarms that are not built
  `MT4A_ASSERT_NOW(a_no_extra_bits, clk, rst, out_valid, extra_bits == 4'd0)

  `MT4A_ASSERT_NEXT(a_word_stable, clk, rst, out_stall, $stable(out_word))

endmodule

bind microsecond_timer_four_alarms mt4a_checker #(
  .NUM_ALARMS(NUM_ALARMS)
) u_mt4a_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .rdata      (rdata),
  .irq_status (irq_status),
  .irq_pulse  (irq_pulse)
);

// ----- tb/microsecond_timer_four_alarms_test.sv -----
`timescale 1ns / 1ps

module microsecond_timer_four_alarms_test;

  localparam int NUM_ALARMS = mt4a_pkg::NUM_ALARMS_DEFAULT;
  localparam logic [3:0] ALARM_MASK = 4'((1 << NUM_ALARMS) - 1);
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] OFF_LOCKED = 8'h34;
  localparam logic [7:0] OFF_SOURCE = 8'h38;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int WORDS_PER_PHASE = 620;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = mt4a_pkg::CMD_READ;
  logic [7:0]  offset = '0;
  logic [1:0]  alias_req = mt4a_pkg::ALIAS_PLAIN;
  logic [31:0] wdata = '0;
  logic [31:0] tick_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] rdata;
  logic [3:0]  irq_status;
  logic [3:0]  irq_pulse;

  // timer state as seen after the last accepted word
  logic [63:0] tm_count;
  logic [31:0] tm_alarm [NUM_ALARMS];
  logic [3:0]  tm_armed;
  logic        tm_pause;
  logic [3:0]  tm_raw;
  logic [3:0]  tm_inte;
  logic [3:0]  tm_intf;

  mt4a_pkg::result_t result_due_q[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      quiet_cycles = 0;
  logic    hold_req = 1'b0;
  logic    hold_seen = 1'b0;
  int      hold_left = 0;

  always #5 clk = ~clk;

  microsecond_timer_four_alarms i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .offset    (offset),
    .alias_req (alias_req),
    .wdata     (wdata),
    .tick_us   (tick_us),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (rdata),
    .irq_status(irq_status),
    .irq_pulse (irq_pulse)
  );

  function automatic logic [3:0] tm_masked();
    return (tm_raw | tm_intf) & tm_inte & ALARM_MASK;
  endfunction

  // alarm slot addressed by an offset, -1 if none
  function automatic int alarm_index(logic [7:0] off);
    int idx;
    if (off < mt4a_pkg::OFF_ALARM_FIRST || off > mt4a_pkg::OFF_ALARM_LAST ||
        off[1:0] != 2'b00) return -1;
    idx = int'(off - mt4a_pkg::OFF_ALARM_FIRST) >> 2;
    return (idx < NUM_ALARMS) ? idx : -1;
  endfunction

  function automatic logic [31:0] tm_read(logic [7:0] off);
    int idx;
    idx = alarm_index(off);
    if (idx >= 0) return tm_alarm[idx];
    case (off)
      mt4a_pkg::OFF_TIMEHR, mt4a_pkg::OFF_TIMERAWH: return tm_count[63:32];
      mt4a_pkg::OFF_TIMELR, mt4a_pkg::OFF_TIMERAWL: return tm_count[31:0];
      mt4a_pkg::OFF_ARMED:  return {28'd0, tm_armed};
      mt4a_pkg::OFF_PAUSE:  return {31'd0, tm_pause};
      mt4a_pkg::OFF_INTR:   return {28'd0, tm_raw};
      mt4a_pkg::OFF_INTE:   return {28'd0, tm_inte};
      mt4a_pkg::OFF_INTF:   return {28'd0, tm_intf};
      mt4a_pkg::OFF_INTS:   return {28'd0, tm_masked()};
      default:              return '0;
    endcase
  endfunction

  function automatic logic [3:0] tm_write(logic [7:0] off, logic [31:0] val);
    int idx;
    idx = alarm_index(off);
    if (idx >= 0) begin
      tm_alarm[idx] = val;
      tm_armed[idx] = 1'b1;
      return '0;
    end
    case (off)
      mt4a_pkg::OFF_TIMEHW: tm_count[63:32] = val;
      mt4a_pkg::OFF_TIMELW: tm_count[31:0] = val;
      mt4a_pkg::OFF_ARMED:  tm_armed &= ~val[3:0] & ALARM_MASK;
      mt4a_pkg::OFF_PAUSE:  tm_pause = val[0];
      mt4a_pkg::OFF_INTR:   tm_raw &= ~val[3:0] & ALARM_MASK;
      mt4a_pkg::OFF_INTE: begin
        tm_inte = val[3:0] & ALARM_MASK;
        return tm_masked();
      end
      mt4a_pkg::OFF_INTF: begin
        tm_intf = val[3:0] & ALARM_MASK;
        return tm_masked();
      end
      default: ;
    endcase
    return '0;
  endfunction

  function automatic logic [3:0] tm_tick(logic [31:0] us);
    logic [3:0]  pulse;
    logic [31:0] diff;
    logic [3:0]  status;
    pulse = '0;
    if (tm_pause || us == '0) return '0;
    tm_count += 64'(us);
    for (int i = 0; i < NUM_ALARMS; i++) begin
      // fires once the low word has reached the alarm, modulo 2^32
      diff = tm_count[31:0] - tm_alarm[i];
      if (tm_armed[i] && !diff[31]) begin
        tm_raw[i] = 1'b1;
        tm_armed[i] = 1'b0;
        status = tm_masked();
        if (status[i]) pulse[i] = 1'b1;
      end
    end
    return pulse;
  endfunction

  function automatic mt4a_pkg::result_t timer_predict(mt4a_pkg::item_t w);
    mt4a_pkg::result_t r;
    logic [31:0]       cur;
    logic [31:0]       val;
    r = '0;
    case (w.cmd)
      mt4a_pkg::CMD_READ: r.rdata = tm_read(w.offset);
      mt4a_pkg::CMD_WRITE: begin
        cur = tm_read(w.offset);
        val = w.wdata;
        // set and clear aliases do not touch the intr write data
        if (w.alias_req == mt4a_pkg::ALIAS_XOR) begin
          val = cur ^ val;
        end else if (w.alias_req == mt4a_pkg::ALIAS_SET && w.offset != mt4a_pkg::OFF_INTR) begin
          val = cur | val;
        end else if (w.alias_req == mt4a_pkg::ALIAS_CLR && w.offset != mt4a_pkg::OFF_INTR) begin
          val = cur & ~val;
        end
        r.irq_pulse = tm_write(w.offset, val);
      end
      mt4a_pkg::CMD_TICK: r.irq_pulse = tm_tick(w.tick_us);
      default: ;
    endcase
    r.irq_status = tm_masked();
    return r;
  endfunction

  function automatic mt4a_pkg::item_t make_word(logic [1:0] c, logic [7:0] off,
                                                logic [1:0] al, logic [31:0] data,
                                                logic [31:0] us);
    mt4a_pkg::item_t w;
    w.cmd = c;
    w.offset = off;
    w.alias_req = al;
    w.wdata = data;
    w.tick_us = us;
    return w;
  endfunction

  // mostly well-formed traffic aimed at the current time, some noise
  function automatic mt4a_pkg::item_t random_word();
    mt4a_pkg::item_t w;
    int              pick;
    logic [31:0]     lo;
    w = make_word(mt4a_pkg::CMD_READ, '0, 2'($urandom_range(0, 3)), $urandom, $urandom);
    pick = $urandom_range(0, 99);
    lo = tm_count[31:0];
    if (pick < 35) begin
      w.cmd = mt4a_pkg::CMD_TICK;
      w.tick_us = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 400);
    end else if (pick < 47) begin
      w.cmd = mt4a_pkg::CMD_WRITE;
      w.offset = mt4a_pkg::OFF_ALARM_FIRST + 8'($urandom_range(0, NUM_ALARMS - 1) * 4);
      if ($urandom_range(0, 3) != 0) w.alias_req = mt4a_pkg::ALIAS_PLAIN;
      w.wdata = lo + $urandom_range(0, 3000) - 300;
    end else if (pick < 62) begin
      w.cmd = mt4a_pkg::CMD_WRITE;
      case ($urandom_range(0, 5))
        0: w.offset = mt4a_pkg::OFF_INTE;
        1: w.offset = mt4a_pkg::OFF_INTF;
        2: w.offset = mt4a_pkg::OFF_INTR;
        3: w.offset = mt4a_pkg::OFF_ARMED;
        4: begin
          w.offset = mt4a_pkg::OFF_PAUSE;
          w.wdata[0] = ($urandom_range(0, 2) == 0);
        end
        default: begin
          w.offset = $urandom_range(0, 1) ? mt4a_pkg::OFF_TIMEHW : mt4a_pkg::OFF_TIMELW;
          if ($urandom_range(0, 1)) w.wdata = 32'hFFFFF000 | $urandom_range(0, 4095);
        end
      endcase
    end else if (pick < 90) begin
      w.offset = 8'($urandom_range(0, 18) * 4);
    end else begin
      w.cmd = 2'($urandom_range(0, 3));
      w.offset = 8'($urandom);
    end
    return w;
  endfunction

  task automatic push_word(mt4a_pkg::item_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= w.cmd;
    offset    <= w.offset;
    alias_req <= w.alias_req;
    wdata     <= w.wdata;
    tick_us   <= w.tick_us;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_due_q.push_back(timer_predict(w));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (result_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send(logic [1:0] c, logic [7:0] off, logic [1:0] al,
                      logic [31:0] data, logic [31:0] us);
    push_word(make_word(c, off, al, data, us));
  endtask

  task automatic test_register_map();
    set_idling(11, 56);
    send(mt4a_pkg::CMD_READ, mt4a_pkg::OFF_TIMEHR, mt4a_pkg::ALIAS_PLAIN, '0, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_TIMEHW, mt4a_pkg::ALIAS_PLAIN, 32'hFFFFFFFF, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_TIMELW, mt4a_pkg::ALIAS_PLAIN, 32'hFFFFFFF0, '0);
    send(mt4a_pkg::CMD_READ, mt4a_pkg::OFF_TIMELR, mt4a_pkg::ALIAS_PLAIN, '0, '0);
    send(mt4a_pkg::CMD_READ, mt4a_pkg::OFF_TIMERAWH, mt4a_pkg::ALIAS_PLAIN, '0, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_ALARM_FIRST, mt4a_pkg::ALIAS_PLAIN, 32'h5, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_INTE, mt4a_pkg::ALIAS_PLAIN, 32'hFFFFFFFF, '0);
    // 64-bit wrap, alarm 0 fires on the way
    send(mt4a_pkg::CMD_TICK, '0, mt4a_pkg::ALIAS_PLAIN, '0, 32'h20);
    send(mt4a_pkg::CMD_TICK, '0, mt4a_pkg::ALIAS_PLAIN, '0, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_PAUSE, mt4a_pkg::ALIAS_PLAIN, 32'h1, '0);
    send(mt4a_pkg::CMD_TICK, '0, mt4a_pkg::ALIAS_PLAIN, '0, 32'hFFFFFFFF);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_PAUSE, mt4a_pkg::ALIAS_CLR, 32'h1, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_INTR, mt4a_pkg::ALIAS_SET, 32'h1, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_INTF, mt4a_pkg::ALIAS_XOR, 32'hF, '0);
    send(mt4a_pkg::CMD_READ, mt4a_pkg::OFF_INTS, mt4a_pkg::ALIAS_PLAIN, '0, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_ALARM_LAST, mt4a_pkg::ALIAS_PLAIN, 32'h7FFFFFFF, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_ARMED, mt4a_pkg::ALIAS_CLR, 32'hF, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_ARMED, mt4a_pkg::ALIAS_SET, 32'h0, '0);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_TIMEHW, mt4a_pkg::ALIAS_XOR, 32'h12345678, '0);
    send(mt4a_pkg::CMD_WRITE, OFF_LOCKED, mt4a_pkg::ALIAS_PLAIN, 32'hFFFFFFFF, '0);
    send(mt4a_pkg::CMD_READ, OFF_SOURCE, mt4a_pkg::ALIAS_XOR, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(mt4a_pkg::CMD_READ, 8'h11, mt4a_pkg::ALIAS_PLAIN, '0, '0);
    send(mt4a_pkg::CMD_READ, 8'hFF, mt4a_pkg::ALIAS_PLAIN, '0, '0);
    send(CMD_UNUSED, mt4a_pkg::OFF_INTE, mt4a_pkg::ALIAS_CLR, 32'hF, 32'h5);
    send(mt4a_pkg::CMD_WRITE, mt4a_pkg::OFF_INTF, mt4a_pkg::ALIAS_PLAIN, 32'h0, '0);
    wait_drain();
  endtask

  task automatic test_mixed_traffic();
    set_idling(11, 56);
    repeat (WORDS_PER_PHASE) push_word(random_word());
    wait_drain();
    set_idling(56, 11);
    repeat (WORDS_PER_PHASE) push_word(random_word());
    wait_drain();
    set_idling(0, 0);
    repeat (WORDS_PER_PHASE) push_word(random_word());
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_req <= ~hold_req;
    repeat (60) push_word(random_word());
    wait_drain();
  endtask

  // result side: random stalls, long hold-off on request, in-order check
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    mt4a_pkg::result_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_due_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got rdata %h status %h pulse %h",
                   $time, rdata, irq_status, irq_pulse);
          mismatches++;
        end else begin
          due = result_due_q.pop_front();
          check_field("rdata", due.rdata, rdata);
          check_field("irq_status", 32'(due.irq_status), 32'(irq_status));
          check_field("irq_pulse", 32'(due.irq_pulse), 32'(irq_pulse));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** microsecond_timer_four_alarms: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tm_count = '0;
    for (int i = 0; i < NUM_ALARMS; i++) tm_alarm[i] = '0;
    tm_armed = '0;
    tm_pause = 1'b0;
    tm_raw = '0;
    tm_inte = '0;
    tm_intf = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_mixed_traffic();
    test_output_backpressure();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** microsecond_timer_four_alarms: PASSED **");
    end else begin
      $display("** microsecond_timer_four_alarms: FAILED **");
    end
    $finish;
  end

endmodule
